/* hdl/kwu_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// kwu_pkg
// Shared widths, reset values and types of the k-th word unranker.
// ============================================================================
package kwu_pkg;

    // Field widths of the request and of the cap register.
    localparam int CNT_W  = 6;
    localparam int RANK_W = 30;
    localparam int CAP_W  = 30;
    localparam int LEN_W  = CNT_W + 1;

    // Reset value of the saturation cap.
    localparam logic [CAP_W-1:0] CAP_RESET = 30'd1000000000;

    // Default longest word and default depth of the request queue.
    localparam int MAX_LEN_DEFAULT     = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // A classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic [CNT_W-1:0]  count_a;
        logic [CNT_W-1:0]  count_z;
        logic [RANK_W-1:0] rank;
        logic              err;
    } kwu_req_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_ERR
    } kwu_back_state_t;

endpackage

/* hdl/kwu_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// kwu_ram
// Generic RAM with one write port and two registered read ports.
// ============================================================================
module kwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_a_en,
    input  logic [ADDR_W-1:0] rd_a_addr,
    output logic [WIDTH-1:0]  rd_a_data,
    input  logic              rd_b_en,
    input  logic [ADDR_W-1:0] rd_b_addr,
    output logic [WIDTH-1:0]  rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports; the data holds until the next read on that port.
    always_ff @(posedge aclk) begin
        if (rd_a_en) begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (rd_b_en) begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

/* hdl/kwu_table_build.sv */
`timescale 1ns / 1ps
// ============================================================================
// kwu_table_build
// Holds the saturation cap and fills the Pascal table one entry per cycle.
// Each word stores the pair {T[n][k-1], T[n][k]} so that the back end gets
// both candidate counts of its next step from one read.
// ============================================================================
module kwu_table_build #(
    parameter int MAX_LEN = kwu_pkg::MAX_LEN_DEFAULT,
    localparam int COL_W  = $clog2(MAX_LEN + 1),
    localparam int DEPTH  = (MAX_LEN + 1) * (MAX_LEN + 1),
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [kwu_pkg::CAP_W-1:0]    cfg_wr_data,
    output logic                         build_done,
    output logic                         ram_wr_en,
    output logic [ADDR_W-1:0]            ram_wr_addr,
    output logic [2*kwu_pkg::CAP_W-1:0]  ram_wr_data
);
    import kwu_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_LEN);

    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic              active_reg, active_next;
    logic [COL_W-1:0]  n_reg, n_next;
    logic [COL_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    // Previous row as a shift line: entry 0 is T[n-1][k] at step k.
    logic [CAP_W-1:0]  row_reg [0:MAX_LEN];
    logic [CAP_W-1:0]  head_prev_reg;
    logic [CAP_W-1:0]  last_v_reg;

    logic [CAP_W:0]    sum;
    logic [CAP_W-1:0]  v;
    logic [CAP_W-1:0]  lo;

    // Entry value: ones on the edges, zeros beyond the diagonal, else a
    // saturated sum of the two entries above.
    always_comb begin
        sum = {1'b0, row_reg[0]} + {1'b0, head_prev_reg};
        if ((k_reg == '0) || (k_reg == n_reg)) begin
            v = CAP_W'(1);
        end else if (k_reg > n_reg) begin
            v = '0;
        end else if (sum > {1'b0, cap_reg}) begin
            v = cap_reg;
        end else begin
            v = sum[CAP_W-1:0];
        end
        lo = (k_reg == '0) ? '0 : last_v_reg;
    end

    assign ram_wr_en   = active_reg;
    assign ram_wr_addr = addr_reg;
    assign ram_wr_data = {lo, v};
    assign build_done  = !active_reg;

    // Sweep counters; a cap write restarts the sweep.
    always_comb begin
        cap_next    = cap_reg;
        active_next = active_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        addr_next   = addr_reg;
        if (cfg_wr_en) begin
            cap_next    = cfg_wr_data;
            active_next = 1'b1;
            n_next      = '0;
            k_next      = '0;
            addr_next   = '0;
        end else if (active_reg) begin
            addr_next = addr_reg + ADDR_W'(1);
            if (k_reg == LAST_COL) begin
                k_next = '0;
                if (n_reg == LAST_COL) begin
                    active_next = 1'b0;
                    n_next      = '0;
                    addr_next   = '0;
                end else begin
                    n_next = n_reg + COL_W'(1);
                end
            end else begin
                k_next = k_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RESET;
            active_reg <= 1'b1;
            n_reg      <= '0;
            k_reg      <= '0;
            addr_reg   <= '0;
        end else begin
            cap_reg    <= cap_next;
            active_reg <= active_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            addr_reg   <= addr_next;
        end
    end

    // Row shift line; after a full row it holds the row just written.
    always_ff @(posedge aclk) begin
        if (active_reg) begin
            for (int i = 0; i < MAX_LEN; i++) begin
                row_reg[i] <= row_reg[i+1];
            end
            row_reg[MAX_LEN] <= v;
            head_prev_reg    <= row_reg[0];
            last_v_reg       <= v;
        end
    end

endmodule

/* hdl/kwu_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// kwu_front
// Accepts requests, reads the word count for the request's lengths and
// marks requests that cannot be served before they enter the queue.
// ============================================================================
module kwu_front #(
    parameter int MAX_LEN = kwu_pkg::MAX_LEN_DEFAULT,
    localparam int DEPTH  = (MAX_LEN + 1) * (MAX_LEN + 1),
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         build_done,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [kwu_pkg::CNT_W-1:0]    s_count_a,
    input  logic [kwu_pkg::CNT_W-1:0]    s_count_z,
    input  logic [kwu_pkg::RANK_W-1:0]   s_rank,
    output logic                         ram_rd_en,
    output logic [ADDR_W-1:0]            ram_rd_addr,
    input  logic [2*kwu_pkg::CAP_W-1:0]  ram_rd_data,
    output logic                         push_valid,
    input  logic                         push_ready,
    output kwu_pkg::kwu_req_t            push_req
);
    import kwu_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

    logic              hold_valid_reg, hold_valid_next;
    logic [CNT_W-1:0]  hold_a_reg;
    logic [CNT_W-1:0]  hold_z_reg;
    logic [RANK_W-1:0] hold_rank_reg;

    logic              accept;
    logic [LEN_W-1:0]  len_in;
    logic [LEN_W-1:0]  hold_len;

    // Take a request when the table is ready and the holding stage frees up.
    assign s_ready = build_done && (!hold_valid_reg || push_ready);
    assign accept  = s_valid && s_ready;

    // Look up T[len][count_z] as the request comes in.
    always_comb begin
        len_in    = {1'b0, s_count_a} + {1'b0, s_count_z};
        ram_rd_en = accept;
        if (len_in <= MAX_LEN_L) begin
            ram_rd_addr = ADDR_W'(int'(len_in) * (MAX_LEN + 1) + int'(s_count_z));
        end else begin
            ram_rd_addr = '0;
        end
    end

    // Classify the held request against the count read from the table.
    always_comb begin
        hold_len         = {1'b0, hold_a_reg} + {1'b0, hold_z_reg};
        push_valid       = hold_valid_reg;
        push_req.count_a = hold_a_reg;
        push_req.count_z = hold_z_reg;
        push_req.rank    = hold_rank_reg;
        push_req.err     = (hold_len == '0) || (hold_len > MAX_LEN_L) ||
                           (hold_rank_reg == '0) ||
                           (hold_rank_reg > ram_rd_data[CAP_W-1:0]);
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (push_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_a_reg    <= s_count_a;
            hold_z_reg    <= s_count_z;
            hold_rank_reg <= s_rank;
        end
    end

endmodule

/* hdl/kwu_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// kwu_queue
// Short request queue between the front end and the back end.
// ============================================================================
module kwu_queue #(
    parameter int DEPTH = kwu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  kwu_pkg::kwu_req_t push_req,
    output logic              pop_valid,
    input  logic              pop_ready,
    output kwu_pkg::kwu_req_t pop_req
);
    import kwu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    kwu_req_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_Q'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_Q'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_Q'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

/* hdl/kwu_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// kwu_back
// Walks one request symbol by symbol, steering the rank with table counts,
// and drives the result register.
// ============================================================================
module kwu_back #(
    parameter int MAX_LEN = kwu_pkg::MAX_LEN_DEFAULT,
    localparam int COL_W  = $clog2(MAX_LEN + 1),
    localparam int DEPTH  = (MAX_LEN + 1) * (MAX_LEN + 1),
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  kwu_pkg::kwu_req_t            pop_req,
    output logic                         ram_rd_en,
    output logic [ADDR_W-1:0]            ram_rd_addr,
    input  logic [2*kwu_pkg::CAP_W-1:0]  ram_rd_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_symbol,
    output logic                         m_status,
    output logic                         m_last
);
    import kwu_pkg::*;

    kwu_back_state_t   state_reg, state_next;
    logic [COL_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  b_reg, b_next;
    logic [CNT_W-1:0]  a_left_reg, a_left_next;
    logic [RANK_W-1:0] k_reg, k_next;
    logic              zlast_reg, zlast_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_symbol_reg, m_symbol_next;
    logic              m_status_reg, m_status_next;
    logic              m_last_reg, m_last_next;

    logic              out_free;
    logic [LEN_W-1:0]  pop_len;
    logic [CAP_W-1:0]  c;
    logic              sym;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_status = m_status_reg;
    assign m_last   = m_last_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    state_next = pop_req.err ? BK_ERR : BK_RUN;
                end
            end
            BK_RUN: begin
                if (out_free && (rem_reg == '0)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_ERR: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Symbol decision: after a 'z' the upper count of the pair, T[n][k-1], applies.
    always_comb begin
        c = zlast_reg ? ram_rd_data[2*CAP_W-1:CAP_W] : ram_rd_data[CAP_W-1:0];
        if (rem_reg == '0) begin
            sym = (a_left_reg == '0);
        end else if (b_reg == '0) begin
            sym = 1'b0;
        end else begin
            sym = (k_reg > c);
        end
    end

    // Outputs and datapath.
    always_comb begin
        pop_ready     = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;
        pop_len       = {1'b0, pop_req.count_a} + {1'b0, pop_req.count_z};
        rem_next      = rem_reg;
        b_next        = b_reg;
        a_left_next   = a_left_reg;
        k_next        = k_reg;
        zlast_next    = zlast_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_symbol_next = m_symbol_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    // Load the walk and fetch the counts of the first row.
                    rem_next    = COL_W'(pop_len - LEN_W'(1));
                    b_next      = pop_req.count_z;
                    a_left_next = pop_req.count_a;
                    k_next      = pop_req.rank;
                    zlast_next  = 1'b0;
                    ram_rd_en   = 1'b1;
                    if (!pop_req.err) begin
                        ram_rd_addr = ADDR_W'((int'(pop_len) - 1) * (MAX_LEN + 1) +
                                              int'(pop_req.count_z));
                    end
                end
            end
            BK_RUN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = sym;
                    m_status_next = 1'b0;
                    m_last_next   = (rem_reg == '0);
                    // Prefetch both candidate counts of the next row.
                    if (rem_reg != '0) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'((int'(rem_reg) - 1) * (MAX_LEN + 1) +
                                              int'(b_reg));
                    end
                    rem_next   = rem_reg - COL_W'(1);
                    zlast_next = sym;
                    if (sym) begin
                        if (b_reg != '0) begin
                            b_next = b_reg - CNT_W'(1);
                        end
                        if ((rem_reg != '0) && (b_reg != '0)) begin
                            k_next = k_reg - c;
                        end
                    end else if (a_left_reg != '0) begin
                        a_left_next = a_left_reg - CNT_W'(1);
                    end
                end
            end
            BK_ERR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = 1'b0;
                    m_status_next = 1'b1;
                    m_last_next   = 1'b1;
                end
            end
            default: begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        b_reg        <= b_next;
        a_left_reg   <= a_left_next;
        k_reg        <= k_next;
        zlast_reg    <= zlast_next;
        m_symbol_reg <= m_symbol_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

endmodule

/* hdl/kth_word_unranker_unit.sv */
`timescale 1ns / 1ps
// The first result of a request passes the front-end holding stage, the queue
// and the back-end walk; a served word then gives one symbol per cycle while
// the output does not stall. The front end and the queue keep taking requests
// while the back end walks a word; the back end takes the next request only
// once the current one is done. Reset and each cap write rebuild the whole
// table, and no request is taken until the rebuild is done.
// ============================================================================
// kth_word_unranker_unit
// Emits the word of a given rank among all words with given symbol counts.
// ============================================================================
module kth_word_unranker_unit #(
    parameter int MAX_LEN     = kwu_pkg::MAX_LEN_DEFAULT,
    parameter int QUEUE_DEPTH = kwu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [kwu_pkg::CAP_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [kwu_pkg::CNT_W-1:0]   s_count_a,
    input  logic [kwu_pkg::CNT_W-1:0]   s_count_z,
    input  logic [kwu_pkg::RANK_W-1:0]  s_rank,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_symbol,
    output logic                        m_status,
    output logic                        m_last
);
    import kwu_pkg::*;

    localparam int DEPTH  = (MAX_LEN + 1) * (MAX_LEN + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = 2 * CAP_W;

    logic              build_done;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_a_en;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [WORD_W-1:0] rd_a_data;
    logic              rd_b_en;
    logic [ADDR_W-1:0] rd_b_addr;
    logic [WORD_W-1:0] rd_b_data;
    logic              push_valid;
    logic              push_ready;
    kwu_req_t          push_req;
    logic              pop_valid;
    logic              pop_ready;
    kwu_req_t          pop_req;

    // Pascal table store.
    kwu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_en   (rd_a_en),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_en   (rd_b_en),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    // Cap register and table fill.
    kwu_table_build #(
        .MAX_LEN (MAX_LEN)
    ) u_build (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .build_done  (build_done),
        .ram_wr_en   (wr_en),
        .ram_wr_addr (wr_addr),
        .ram_wr_data (wr_data)
    );

    // Request intake and classification.
    kwu_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .build_done  (build_done),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_count_a   (s_count_a),
        .s_count_z   (s_count_z),
        .s_rank      (s_rank),
        .ram_rd_en   (rd_a_en),
        .ram_rd_addr (rd_a_addr),
        .ram_rd_data (rd_a_data),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_req    (push_req)
    );

    // Queue between the two halves.
    kwu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    // Symbol walk and result register.
    kwu_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_req     (pop_req),
        .ram_rd_en   (rd_b_en),
        .ram_rd_addr (rd_b_addr),
        .ram_rd_data (rd_b_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_symbol    (m_symbol),
        .m_status    (m_status),
        .m_last      (m_last)
    );

endmodule

/* tb/sv/kth_word_unranker_unit_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// kth_word_unranker_unit_test
// Self-checking bench for the k-th word unranker. It sends requests
// (symbol counts and a rank) and predicts each word with its own copy of
// the saturating Pascal table. Every symbol result is checked in order
// against that prediction. The run covers corner requests, several cap
// settings, random traffic with bursty input, and output back-pressure.
// ============================================================================
module kth_word_unranker_unit_test;

    import kwu_pkg::*;

    localparam int WORD_MAX    = MAX_LEN_DEFAULT;
    // Cycles to let the block settle once every expected result has come.
    localparam int IDLE_SETTLE = 2 * (WORD_MAX + 1) + 10;

    // Symbol and status codes of one result.
    localparam bit SYM_A           = 1'b0;
    localparam bit SYM_Z           = 1'b1;
    localparam bit STATUS_OK       = 1'b0;
    localparam bit STATUS_REJECTED = 1'b1;

    // Patterns the result receiver cycles through.
    typedef enum int {
        FLOW_FREE,
        FLOW_RANDOM,
        FLOW_PERIODIC,
        FLOW_SPARSE
    } flow_mode_t;

    typedef struct packed {
        bit symbol;
        bit status;
        bit last;
    } word_result_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [CNT_W-1:0]  s_count_a   = '0;
    logic [CNT_W-1:0]  s_count_z   = '0;
    logic [RANK_W-1:0] s_rank      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic              m_symbol;
    logic              m_status;
    logic              m_last;

    // Predicted state: the cap and the saturating binomial table.
    bit [CAP_W-1:0] cap_value;
    bit [CAP_W-1:0] binom_table [0:WORD_MAX][0:WORD_MAX];
    word_result_t   pending_symbols [$];

    int fail_count      = 0;
    int requests_sent   = 0;
    int symbols_checked = 0;
    int cap_settings    = 1;

    // Sender burst control and receiver hold-off request.
    bit sender_gaps_on  = 1'b1;
    int burst_left      = 0;
    int holdoff_request = 0;

    kth_word_unranker_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_count_a  (s_count_a),
        .s_count_z  (s_count_z),
        .s_rank     (s_rank),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_symbol   (m_symbol),
        .m_status   (m_status),
        .m_last     (m_last)
    );

    always #5 aclk = ~aclk;

    // Rebuild the Pascal table, saturating every computed entry at the cap.
    function automatic void rebuild_binom_table();
        int unsigned sum;
        for (int n = 0; n <= WORD_MAX; n++) begin
            for (int k = 0; k <= WORD_MAX; k++) begin
                binom_table[n][k] = '0;
            end
            binom_table[n][0] = CAP_W'(1);
            binom_table[n][n] = CAP_W'(1);
            for (int k = 1; k < n; k++) begin
                sum = int'(binom_table[n-1][k]) + int'(binom_table[n-1][k-1]);
                binom_table[n][k] = (sum > cap_value) ? cap_value : sum[CAP_W-1:0];
            end
        end
    endfunction

    // Number of words with the given counts, as stored; 0 when out of range.
    function automatic int unsigned rank_limit(input bit [CNT_W-1:0] na,
                                               input bit [CNT_W-1:0] nz);
        int unsigned len;
        len = 32'(na) + 32'(nz);
        if (len == 0 || len > WORD_MAX) begin
            return 0;
        end
        return 32'(binom_table[len][nz]);
    endfunction

    // Work out the word of the given rank and queue its symbol results.
    function automatic void unrank_word(input bit [CNT_W-1:0] na,
                                        input bit [CNT_W-1:0] nz,
                                        input bit [RANK_W-1:0] rank);
        int unsigned len, left, z_left, a_left, rem, steer;
        word_result_t res;
        len    = 32'(na) + 32'(nz);
        left   = 32'(rank);
        z_left = 32'(nz);
        a_left = 32'(na);
        if (len == 0 || len > WORD_MAX || left == 0 || left > binom_table[len][nz]) begin
            res.symbol = SYM_A;
            res.status = STATUS_REJECTED;
            res.last   = 1'b1;
            pending_symbols.push_back(res);
            return;
        end
        for (int pos = 0; pos < len; pos++) begin
            rem = len - 1 - pos;
            if (rem == 0) begin
                res.symbol = (a_left != 0) ? SYM_A : SYM_Z;
            end else if (z_left == 0) begin
                res.symbol = SYM_A;
            end else begin
                // Words starting with 'a' come first; skip them if the rank is past.
                steer = (z_left <= rem) ? 32'(binom_table[rem][z_left]) : 0;
                if (left > steer) begin
                    res.symbol = SYM_Z;
                    left -= steer;
                end else begin
                    res.symbol = SYM_A;
                end
            end
            if (res.symbol == SYM_Z) begin
                if (z_left > 0) z_left--;
            end else begin
                if (a_left > 0) a_left--;
            end
            res.status = STATUS_OK;
            res.last   = (rem == 0);
            pending_symbols.push_back(res);
        end
    endfunction

    // Offer one request, with random gaps between bursts, and predict it
    // once it is accepted.
    task automatic send_request(input bit [CNT_W-1:0] na, input bit [CNT_W-1:0] nz,
                                input bit [RANK_W-1:0] rank);
        int gap;
        if (sender_gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(8, 1);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(12, 1);
        end
        if (burst_left > 0) burst_left--;
        s_valid   <= 1'b1;
        s_count_a <= na;
        s_count_z <= nz;
        s_rank    <= rank;
        do @(posedge aclk); while (!s_ready);
        unrank_word(na, nz, rank);
        requests_sent++;
    endtask

    // Mostly well-formed requests of small length with in-range ranks; the
    // rest are out-of-range ranks and raw noise.
    task automatic send_random_request();
        int pick, len;
        int unsigned limit;
        bit [CNT_W-1:0] na, nz;
        bit [RANK_W-1:0] rank;
        pick = $urandom_range(99, 0);
        if (pick < 12) begin
            na   = CNT_W'($urandom);
            nz   = CNT_W'($urandom);
            rank = RANK_W'($urandom);
        end else begin
            len = (pick < 70) ? $urandom_range(12, 1) : $urandom_range(WORD_MAX, 1);
            na  = CNT_W'($urandom_range((len > 63) ? 63 : len, (len > 63) ? len - 63 : 0));
            nz  = CNT_W'(len - int'(na));
            limit = rank_limit(na, nz);
            pick  = $urandom_range(99, 0);
            if (pick < 88) begin
                rank = RANK_W'($urandom_range(limit, 1));
            end else if (pick < 93) begin
                rank = RANK_W'(limit + 1);
            end else if (pick < 96) begin
                rank = '0;
            end else begin
                rank = RANK_W'($urandom);
            end
        end
        send_request(na, nz, rank);
    endtask

    // Stop sending and wait until every predicted result has arrived.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge aclk);
    endtask

    task automatic drain_results();
        wait_all_results();
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // Write the cap while the block is idle and rebuild the predicted table.
    task automatic write_cap(input bit [CAP_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_value = value;
        rebuild_binom_table();
        cap_settings++;
    endtask

    // Corner requests under the reset cap.
    task automatic test_corner_requests();
        send_request(1, 1, 1);
        send_request(1, 1, 2);
        send_request(1, 1, 3);                 // rank past the word count
        send_request(0, 0, 1);                 // empty word
        send_request(3, 0, 1);                 // no 'z' at all
        send_request(0, 3, 1);
        send_request(63, 63, 1);               // longer than the longest word
        send_request(63, 1, 1);
        send_request(1, 63, 64);
        send_request(1, 63, 65);
        send_request(2, 2, 0);                 // rank zero
        send_request(2, 2, '1);
        send_request(32, 32, 1);
        send_request(32, 32, 1000000000);      // saturated count at the cap
        send_request(32, 32, 1000000001);
        send_request(2, 2, 6);
        send_request(3, 2, 4);
        send_request(0, 1, 1);                 // final position with only 'z' left
        send_request(1, 0, 1);
        send_request(0, 63, 1);
        send_request(63, 0, 1);
        send_request(30, 34, 123456789);
        send_request(10, 10, 184756);
        send_request(60, 4, 635376);
        send_request(21, 42, RANK_W'($urandom_range(rank_limit(21, 42), 1)));
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            send_random_request();
        end
    endtask

    // Hold the receiver off for a long stretch while requests keep coming.
    task automatic test_receiver_holdoff();
        holdoff_request = 400;
        sender_gaps_on  = 1'b0;
        for (int i = 0; i < 12; i++) begin
            send_random_request();
        end
        sender_gaps_on = 1'b1;
    endtask

    // Let the block run dry in the middle of traffic.
    task automatic test_sender_drain_pause();
        for (int i = 0; i < 5; i++) begin
            send_random_request();
        end
        wait_all_results();
        for (int i = 0; i < 5; i++) begin
            send_random_request();
        end
    endtask

    // Steering with saturated counts over a range of caps, extremes included.
    task automatic test_saturation_caps();
        bit [CAP_W-1:0] caps [5];
        caps[0] = 1;
        caps[1] = 2;
        caps[2] = 37;
        caps[3] = CAP_W'($urandom_range(200000, 1000));
        caps[4] = 1000000000;
        foreach (caps[c]) begin
            write_cap(caps[c]);
            send_request(32, 32, caps[c]);
            send_request(32, 32, RANK_W'(caps[c] + 1));
            for (int i = 0; i < 12; i++) begin
                send_random_request();
            end
        end
    endtask

    // Result receiver: stall patterns of its own, plus the long hold-off.
    always @(posedge aclk) begin : result_receiver
        static flow_mode_t mode = FLOW_FREE;
        static int mode_left = 0;
        static int holdoff_left = 0;
        static int phase = 0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (holdoff_request > 0) begin
                holdoff_left    = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = flow_mode_t'($urandom_range(3, 0));
                    mode_left = $urandom_range(200, 40);
                end
                mode_left--;
                phase++;
                case (mode)
                    FLOW_FREE:     m_ready <= 1'b1;
                    FLOW_RANDOM:   m_ready <= 1'($urandom_range(1, 0));
                    FLOW_PERIODIC: m_ready <= (phase % 3) != 0;
                    default:       m_ready <= (phase % 4) == 0;
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_checker
        word_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_symbols.size() == 0) begin
                $error("result with no request pending: symbol %0d status %0d last %0d",
                       m_symbol, m_status, m_last);
                fail_count++;
            end else begin
                want = pending_symbols.pop_front();
                if (m_symbol !== want.symbol) begin
                    $error("m_symbol mismatch: expected %0d, got %0d", want.symbol, m_symbol);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $error("m_status mismatch: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("m_last mismatch: expected %0d, got %0d", want.last, m_last);
                    fail_count++;
                end
            end
            symbols_checked++;
        end
    end

    // Main sequence.
    initial begin
        cap_value = CAP_RESET;
        rebuild_binom_table();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_corner_requests();
        test_random_traffic(100);
        test_receiver_holdoff();
        test_sender_drain_pause();
        test_saturation_caps();
        drain_results();
        $display("summary: %0d requests sent, %0d results checked, %0d cap settings",
                 requests_sent, symbols_checked, cap_settings);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
